[hdl/hrfl_pkg.sv]
// shared types, codes and constants of the hex record flash loader
`timescale 1ns / 1ps
`default_nettype none

package hrfl_pkg;

  // result action codes
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ERASE = 2'd1;
  localparam logic [1:0] ACT_ACK   = 2'd2;
  localparam logic [1:0] ACT_DONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_START      = 2'd0;
  localparam logic [1:0] REG_LINE_BREAK = 2'd1;
  localparam logic [1:0] REG_END        = 2'd2;

  // configuration reset values
  localparam logic [7:0] START_CHAR_RST      = 8'd64;
  localparam logic [7:0] LINE_BREAK_CHAR_RST = 8'd10;
  localparam logic [7:0] END_CHAR_RST        = 8'd35;

  // character decoding
  localparam logic [7:0] DIGIT_ZERO   = 8'd48;
  localparam logic [7:0] DIGIT_NINE   = 8'd57;
  localparam logic [7:0] ALPHA_OFFSET = 8'd55;

  // record kinds that carry meaning
  localparam logic [3:0] KIND_DATA    = 4'd0;
  localparam logic [3:0] KIND_EXT_LIN = 4'd4;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF0000;
  localparam logic [15:0] PAD_HIGH   = 16'hFF00;

  localparam int LINE_LIMIT_DEF = 512;
  localparam int TDATA_W        = 56;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] line_break_char;
    logic [7:0] end_char;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] flash_address;
    logic [15:0] halfword;
    logic        last;
  } result_t;

  // results caused by one character
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[DIGIT_ZERO:DIGIT_NINE]}) begin
      v = c - DIGIT_ZERO;
    end else begin
      v = c - ALPHA_OFFSET;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

[hdl/hrfl_parser.sv]
// record line state and per-character decode
`timescale 1ns / 1ps
`default_nettype none

module hrfl_parser #(
  parameter int LINE_LIMIT = hrfl_pkg::LINE_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire logic [7:0]            rx_char,
  input  wire hrfl_pkg::cfg_t        cfg,
  output hrfl_pkg::result_pair_t     res
);
  import hrfl_pkg::*;

  localparam int POS_W = $clog2(LINE_LIMIT + 1);
  localparam int GRP_W = POS_W - 2;
  localparam int CMP_W = (GRP_W > 7) ? GRP_W : 7;

  logic [POS_W-1:0] line_position, line_position_next;
  logic [7:0]       byte_count, byte_count_next;
  logic [3:0]       record_kind, record_kind_next;
  logic [15:0]      upper_address, upper_address_next;
  logic [15:0]      lower_address, lower_address_next;
  logic [11:0]      digit_accumulator, digit_accumulator_next;
  logic [6:0]       halfword_index, halfword_index_next;
  logic             finished, finished_next;

  logic [3:0]       d;
  logic [POS_W-1:0] rel;
  logic [CMP_W-1:0] grp, pairs;
  logic [1:0]       off;
  logic             take;
  logic [15:0]      v;
  logic [31:0]      wr_addr;
  result_t          r_ack, r_write;

  always_comb begin
    d       = digit_of(rx_char);
    rel     = line_position - POS_W'(9);
    grp     = CMP_W'(rel[POS_W-1:2]);
    off     = rel[1:0];
    pairs   = CMP_W'(byte_count[7:1]);
    v       = {digit_accumulator, d};
    wr_addr = (({16'd0, upper_address} << 16) & UPPER_MASK)
              + {16'd0, lower_address} + {24'd0, halfword_index, 1'b0};
    take    = 1'b0;
    if (record_kind == KIND_DATA) begin
      take = (grp < pairs) || ((grp == pairs) && byte_count[0] && (off < 2'd2));
    end else if (record_kind == KIND_EXT_LIN) begin
      take = line_position <= POS_W'(12);
    end
  end

  always_comb begin
    r_ack  = '{action: ACT_ACK, flash_address: 32'd0, halfword: 16'd0, last: 1'b1};
    r_write = '{action: ACT_WRITE, flash_address: wr_addr, halfword: 16'd0, last: 1'b1};

    line_position_next     = line_position;
    byte_count_next        = byte_count;
    record_kind_next       = record_kind;
    upper_address_next     = upper_address;
    lower_address_next     = lower_address;
    digit_accumulator_next = digit_accumulator;
    halfword_index_next    = halfword_index;
    finished_next          = finished;
    res                    = '0;

    if (finished) begin
      // download over, everything is dropped
    end else if (rx_char == cfg.start_char || rx_char == cfg.line_break_char) begin
      if (rx_char == cfg.start_char) begin
        res.count = 2'd2;
        res.first = '{action: ACT_ERASE, flash_address: 32'd0, halfword: 16'd0,
                      last: 1'b0};
        res.second = r_ack;
      end else if (line_position >= POS_W'(9) && record_kind == KIND_DATA
                   && byte_count[0]) begin
        // odd trailing byte padded high
        res.count = 2'd2;
        res.first = r_write;
        res.first.halfword = PAD_HIGH | {8'd0, digit_accumulator[7:0]};
        res.first.last = 1'b0;
        res.second = r_ack;
      end else begin
        res.count = 2'd1;
        res.first = r_ack;
      end
      line_position_next     = '0;
      byte_count_next        = '0;
      record_kind_next       = '0;
      digit_accumulator_next = '0;
      halfword_index_next    = '0;
    end else if (rx_char == cfg.end_char) begin
      finished_next = 1'b1;
      res.count = 2'd1;
      res.first = '{action: ACT_DONE, flash_address: 32'd0, halfword: 16'd0, last: 1'b1};
    end else if (line_position < POS_W'(LINE_LIMIT)) begin
      line_position_next = line_position + POS_W'(1);
      if (line_position == POS_W'(1) || line_position == POS_W'(3)) begin
        digit_accumulator_next = {8'd0, d};
      end else if (line_position == POS_W'(2)) begin
        byte_count_next        = {digit_accumulator[3:0], d};
        digit_accumulator_next = '0;
      end else if (line_position == POS_W'(4) || line_position == POS_W'(5)) begin
        digit_accumulator_next = {digit_accumulator[7:0], d};
      end else if (line_position == POS_W'(6)) begin
        lower_address_next     = v;
        digit_accumulator_next = '0;
      end else if (line_position == POS_W'(8)) begin
        record_kind_next = d;
      end else if (line_position >= POS_W'(9) && take) begin
        if (off == 2'd0) begin
          digit_accumulator_next = {8'd0, d};
        end else if (off != 2'd3) begin
          digit_accumulator_next = {digit_accumulator[7:0], d};
        end else begin
          digit_accumulator_next = '0;
          if (record_kind == KIND_EXT_LIN) begin
            upper_address_next = v;
          end else begin
            // record byte order puts the first byte low
            res.count = 2'd1;
            res.first = r_write;
            res.first.halfword = {v[7:0], v[15:8]};
            halfword_index_next = halfword_index + 7'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position     <= '0;
      byte_count        <= '0;
      record_kind       <= '0;
      upper_address     <= '0;
      lower_address     <= '0;
      digit_accumulator <= '0;
      halfword_index    <= '0;
      finished          <= 1'b0;
    end else if (fire) begin
      line_position     <= line_position_next;
      byte_count        <= byte_count_next;
      record_kind       <= record_kind_next;
      upper_address     <= upper_address_next;
      lower_address     <= lower_address_next;
      digit_accumulator <= digit_accumulator_next;
      halfword_index    <= halfword_index_next;
      finished          <= finished_next;
    end
  end

endmodule

`default_nettype wire

[hdl/hrfl_result_buf.sv]
// two-slot result register feeding the output stream
`timescale 1ns / 1ps
`default_nettype none

module hrfl_result_buf (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire hrfl_pkg::result_pair_t pair,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output hrfl_pkg::result_t           out_res,
  output logic                        room
);
  import hrfl_pkg::*;

  logic [1:0] cnt;
  result_t    slot0, slot1;
  logic       pop;

  assign out_valid = cnt != 2'd0;
  assign out_res   = slot0;
  assign pop       = out_valid && out_ready;
  // empty, or its only entry leaves this cycle
  assign room      = (cnt == 2'd0) || (cnt == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push) begin
      cnt <= pair.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= pair.first;
      slot1 <= pair.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

`default_nettype wire

[hdl/hex_record_flash_loader_core.sv]
// top level of the hex record flash loader
//
//  port group | dir | payload                                   | marker
//  s_*        | in  | s_tdata[7:0] rx_char                      | -
//  m_*        | out | action, flash_address, halfword (tdata)   | tlast = last
//  cfg_*      | in  | cfg_index selects register, cfg_data      | cfg_we
//
// a character moves into an input register, then is decoded combinationally against
// the line state and its results land in a two-slot result register
// one character per cycle is taken while the output keeps up; a character with two
// results (start, or a line break with a padded write) holds the output for two
// transfers and holds back the next character until the first result has left
// reset (rst, synchronous) clears line state, addresses, the finished flag, empties
// the input and result registers and restores the configuration reset values
// output stall backs up into the input register, then s_tready drops
`timescale 1ns / 1ps
`default_nettype none

module hex_record_flash_loader_core #(
  parameter int LINE_LIMIT = hrfl_pkg::LINE_LIMIT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // stream in
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // [7:0] rx_char
  // stream out
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [hrfl_pkg::TDATA_W-1:0]      m_tdata,   // [1:0] action, [33:2] flash_address,
                                                       // [49:34] halfword, rest zero
  output logic                              m_tlast,
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [7:0]                   cfg_data
);
  import hrfl_pkg::*;

  cfg_t         cfg;
  logic         in_valid;
  logic [7:0]   in_char;
  logic         fire;
  logic         room;
  result_pair_t pair;
  result_t      out_res;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_char      <= START_CHAR_RST;
      cfg.line_break_char <= LINE_BREAK_CHAR_RST;
      cfg.end_char        <= END_CHAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START:      cfg.start_char      <= cfg_data;
        REG_LINE_BREAK: cfg.line_break_char <= cfg_data;
        REG_END:        cfg.end_char        <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode fires once the result register can take both possible results
  assign fire     = in_valid && room;
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
    end
  end

  hrfl_parser #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_char (in_char),
    .cfg     (cfg),
    .res     (pair)
  );

  hrfl_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .pair      (pair),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .room      (room)
  );

  // pack result fields from bit 0 up
  assign m_tdata = {6'd0, out_res.halfword, out_res.flash_address, out_res.action};
  assign m_tlast = out_res.last;

  // a decoded character with results shows one on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    fire && pair.count != 2'd0 |=> m_tvalid)
    else $error("decoded results not presented");

  // erase is always followed by an acknowledge from the same character
  a_erase_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ACT_ERASE |-> !m_tlast)
    else $error("erase marked last");

  // only writes carry an address or a halfword
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ACT_WRITE |-> m_tdata[49:2] == 48'd0)
    else $error("non-write result carries address or data");

  // the result register never decodes into a slot still waiting
  a_room: assert property (@(posedge clk) disable iff (rst)
    fire && m_tvalid |-> m_tready)
    else $error("decode over a pending result");

endmodule

`default_nettype wire

[dv/hex_record_flash_loader_core_tb.sv]
// self-checking testbench for the hex record flash loader core
`timescale 1ns / 1ps

module hex_record_flash_loader_core_tb;
  import hrfl_pkg::*;

  localparam int DRAIN_CYCLES = 16;   // extra idle clocks once every expected result has come out
  localparam int PHASE_CHARS  = 160;

  // loader model: decodes each accepted character into the expected flash actions
  class load_scoreboard;
    logic [7:0]  start_char;
    logic [7:0]  line_break_char;
    logic [7:0]  end_char;
    int unsigned line_pos;
    logic [7:0]  byte_count;
    logic [3:0]  kind;
    logic [15:0] upper_addr;
    logic [15:0] lower_addr;
    logic [11:0] acc;
    logic [6:0]  hw_idx;
    bit          finished;
    result_t     expected_results[$];
    int          errors;
    int          chars_seen;
    int          n_write, n_erase, n_ack, n_done;

    function new();
      start_char      = START_CHAR_RST;
      line_break_char = LINE_BREAK_CHAR_RST;
      end_char        = END_CHAR_RST;
      upper_addr      = '0;
      lower_addr      = '0;
      finished        = 0;
      clear_line();
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_START:      start_char = value;
        REG_LINE_BREAK: line_break_char = value;
        REG_END:        end_char = value;
        default: ;
      endcase
    endfunction

    function void clear_line();
      line_pos   = 0;
      byte_count = '0;
      kind       = '0;
      acc        = '0;
      hw_idx     = '0;
    endfunction

    function logic [31:0] write_address();
      return {upper_addr, lower_addr} + {24'd0, hw_idx, 1'b0};
    endfunction

    function logic [3:0] hex_value(logic [7:0] c);
      logic [7:0] t;
      t = (c >= DIGIT_ZERO && c <= DIGIT_NINE) ? c - DIGIT_ZERO : c - ALPHA_OFFSET;
      return t[3:0];
    endfunction

    function void push(logic [1:0] act, logic [31:0] addr, logic [15:0] hw, logic fin);
      result_t r;
      r.action        = act;
      r.flash_address = addr;
      r.halfword      = hw;
      r.last          = fin;
      expected_results.push_back(r);
      case (act)
        ACT_WRITE: n_write++;
        ACT_ERASE: n_erase++;
        ACT_ACK:   n_ack++;
        default:   n_done++;
      endcase
    endfunction

    // one accepted character on the input stream
    function void note_char(logic [7:0] c);
      logic [3:0]  d;
      logic [15:0] v;
      int unsigned pos, grp, off, pairs;
      bit          take;
      chars_seen++;
      if (finished) return;
      // control characters, start first, then line break, then end
      if (c == start_char) begin
        clear_line();
        push(ACT_ERASE, '0, '0, 1'b0);
        push(ACT_ACK, '0, '0, 1'b1);
        return;
      end
      if (c == line_break_char) begin
        // odd trailing byte of a data line goes out padded
        if (line_pos >= 9 && kind == KIND_DATA && byte_count[0])
          push(ACT_WRITE, write_address(), PAD_HIGH | {8'h00, acc[7:0]}, 1'b0);
        clear_line();
        push(ACT_ACK, '0, '0, 1'b1);
        return;
      end
      if (c == end_char) begin
        finished = 1;
        push(ACT_DONE, '0, '0, 1'b1);
        return;
      end
      if (line_pos >= LINE_LIMIT_DEF) return;
      pos = line_pos;
      line_pos++;
      d = hex_value(c);
      if (pos == 1 || pos == 3) begin
        acc = {8'd0, d};
      end else if (pos == 2) begin
        byte_count = {acc[3:0], d};
        acc = '0;
      end else if (pos == 4 || pos == 5) begin
        acc = {acc[7:0], d};
      end else if (pos == 6) begin
        lower_addr = {acc, d};
        acc = '0;
      end else if (pos == 8) begin
        kind = d;
      end else if (pos >= 9) begin
        grp   = (pos - 9) >> 2;
        off   = (pos - 9) & 3;
        pairs = byte_count >> 1;
        take  = 0;
        if (kind == KIND_DATA)
          take = grp < pairs || (grp == pairs && byte_count[0] && off < 2);
        else if (kind == KIND_EXT_LIN)
          take = pos <= 12;
        if (!take) return;
        if (off == 0) begin
          acc = {8'd0, d};
        end else if (off < 3) begin
          acc = {acc[7:0], d};
        end else begin
          v = {acc, d};
          acc = '0;
          if (kind == KIND_EXT_LIN) begin
            upper_addr = v;
          end else begin
            // first record byte lands in the low half
            push(ACT_WRITE, write_address(), {v[7:0], v[15:8]}, 1'b1);
            hw_idx = hw_idx + 7'd1;
          end
        end
      end
    endfunction

    // one accepted transfer on the output stream
    function void check_result(logic [1:0] act, logic [31:0] addr, logic [15:0] hw,
                               logic fin);
      result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected transfer: action %0d address %08h halfword %04h", act, addr, hw);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (act !== e.action) begin
        $error("action: expected %0d, got %0d", e.action, act);
        errors++;
      end
      if (addr !== e.flash_address) begin
        $error("flash_address: expected %08h, got %08h", e.flash_address, addr);
        errors++;
      end
      if (hw !== e.halfword) begin
        $error("halfword: expected %04h, got %04h", e.halfword, hw);
        errors++;
      end
      if (fin !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tlast;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [7:0]          cfg_data;

  load_scoreboard sb;
  bit             idle_on;
  int             n_settings;
  int             n_long_lines;

  hex_record_flash_loader_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // [7:0] rx_char
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // [1:0] action, [33:2] flash_address, [49:34] halfword
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random stall bursts while idling is on, steady ready otherwise
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // every output transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[1:0], m_tdata[33:2], m_tdata[49:34], m_tlast);
  end

  // random character that hits none of the control characters
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == sb.start_char || c == sb.line_break_char || c == sb.end_char);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? DIGIT_ZERO + 8'(n) : ALPHA_OFFSET + 8'(n);
  endfunction

  // mostly a clean hex digit, now and then any other character
  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if ($urandom_range(0, 29) == 0) return noise_char();
    return hex_char(n);
  endfunction

  // one character transfer on the input stream, with an optional gap before it
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c);
  endtask

  task automatic send_hex(input logic [15:0] value, input int digits);
    for (int i = digits - 1; i >= 0; i--) send_char(digit_char(value[i*4 +: 4]));
  endtask

  // stop sending, let every expected result come out, then allow for latency
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // called only when the block is idle
  task automatic load_registers(input logic [7:0] st, input logic [7:0] lb,
                                input logic [7:0] en);
    logic [7:0] vals[3];
    logic [1:0] idx[3];
    vals = '{st, lb, en};
    idx  = '{REG_START, REG_LINE_BREAK, REG_END};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_register(idx[i], vals[i]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // data line with the largest byte count, runs past the line limit
  task automatic send_long_line();
    send_char(":");
    send_hex(16'h00FF, 2);
    send_hex(16'($urandom), 4);
    send_hex({12'd0, KIND_DATA}, 2);
    for (int i = 0; i < 520; i++) send_char(hex_char(4'($urandom_range(0, 15))));
    send_char(sb.line_break_char);
    n_long_lines++;
  endtask

  // one record with random content, sometimes short, overlong or broken
  task automatic send_record();
    int unsigned pick, cnt, ndata;
    logic [3:0]  kind;
    logic [15:0] addr;
    bit          all_f;
    pick = $urandom_range(0, 99);
    if (pick < 55)      kind = KIND_DATA;
    else if (pick < 75) kind = KIND_EXT_LIN;
    else                kind = 4'($urandom_range(0, 15));
    cnt   = (kind == KIND_EXT_LIN) ? 2 : $urandom_range(0, 17);
    addr  = ($urandom_range(0, 4) == 0) ? {12'hFFF, 4'($urandom_range(0, 15))}
                                        : 16'($urandom);
    all_f = (kind == KIND_EXT_LIN) && $urandom_range(0, 2) == 0;
    send_char(($urandom_range(0, 9) == 0) ? noise_char() : 8'h3A);
    send_hex(16'(cnt), 2);
    send_hex(addr, 4);
    send_hex({12'd0, kind}, 2);
    ndata = 2 * cnt;
    case ($urandom_range(0, 9))
      0:       ndata = $urandom_range(0, ndata);        // line cut short
      1:       ndata = ndata + $urandom_range(1, 10);   // trailing junk digits
      default: ndata = ndata + 2;                       // checksum
    endcase
    for (int i = 0; i < ndata; i++)
      send_char(digit_char((all_f && i < 4) ? 4'hF : 4'($urandom_range(0, 15))));
    pick = $urandom_range(0, 19);
    if (pick == 0)      send_char(sb.start_char);   // restart mid line
    else if (pick != 1) send_char(sb.line_break_char);
  endtask

  // random part of one register setting
  task automatic run_random(input int n, input bit with_long, input bit calm);
    int  target;
    bit  paused;
    if (with_long) send_long_line();
    target = sb.chars_seen + n;
    paused = 0;
    while (sb.chars_seen < target) begin
      idle_on = calm ? 1'b0 : ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 11) == 0) begin
        // pure noise line
        repeat ($urandom_range(1, 20)) send_char(noise_char());
        send_char(sb.line_break_char);
      end else begin
        send_record();
      end
      if (!paused && sb.chars_seen >= target - n / 2) begin
        // sender holds off until the output side has caught up
        wait_drained();
        paused = 1;
      end
    end
  endtask

  initial begin
    string first_line;
    first_line = ":03FFFE00A1B2C3";
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= REG_START;
    cfg_data  <= 8'h00;
    sb         = new();
    idle_on    = 1'b1;
    n_settings = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: erase, a data line crossing a 64k boundary with an odd byte,
    // then the character extremes on a line too short to write anything
    send_char(START_CHAR_RST);
    for (int i = 0; i < first_line.len(); i++) send_char(first_line[i]);
    send_char(LINE_BREAK_CHAR_RST);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(LINE_BREAK_CHAR_RST);

    run_random(PHASE_CHARS, 0, 0);

    // register extremes, clashes resolved by priority
    wait_drained();
    load_registers(8'h00, 8'hFF, 8'h00);
    run_random(PHASE_CHARS, 1, 0);
    wait_drained();
    load_registers(8'hFF, 8'h00, 8'hFF);
    run_random(PHASE_CHARS, 0, 0);
    wait_drained();
    load_registers(8'h53, 8'h0D, 8'h0D);
    run_random(PHASE_CHARS, 1, 0);

    // last setting runs without any idling and ends the download
    wait_drained();
    idle_on = 1'b0;
    load_registers(8'h40, 8'h0A, 8'h21);
    run_random(PHASE_CHARS, 0, 1);
    send_char(sb.end_char);
    // everything after the end character is dropped
    send_char(sb.end_char);
    send_char(sb.start_char);
    send_char(sb.line_break_char);
    send_char(8'h3A);
    wait_drained();

    $display("covered %0d characters under %0d register settings, %0d overlong lines",
             sb.chars_seen, n_settings, n_long_lines);
    $display("checked %0d halfword writes, %0d erases, %0d line acks, %0d download end",
             sb.n_write, sb.n_erase, sb.n_ack, sb.n_done);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
